### rtl/sps_pkg.sv
// Shared widths, limits and types for the square part splitter.
`timescale 1ns / 1ps

package sps_pkg;

    localparam int VALUE_W = 40;
    localparam int OUT_W   = 20;
    localparam int CNT_W   = $clog2(VALUE_W);

    localparam logic [VALUE_W-1:0] SPLIT_LIMIT = 40'd1000000000000;

    typedef struct packed {
        logic [VALUE_W-1:0] quot;
        logic [VALUE_W-1:0] rem;
    } t_div_res;

endpackage

### rtl/square_part_splitter.sv
// Top level: trial-division sequencer around a shared divider and multiplier.
`timescale 1ns / 1ps
// Splits i_value as o_outside_part^2 * o_inside_part, o_inside_part square-free.
// Input channel: an item is taken at a rising edge with start high and busy low.
// For values that go to trial division, busy stays high from then until the result strobe.
// Output channel: o_valid is high for exactly one cycle with the result fields;
// the receiver cannot stall, so the result must be captured in that cycle.
// Values above 10^12 come back with o_accepted low and both parts zero, and
// zero comes back as outside 0, inside 1; both answer in the cycle after start.
// Other values run trial division over 2 and then the odd numbers from 3 up, through
// one 40-bit restoring divider at one quotient bit per cycle. One division
// tests each divisor, plus one per factor removed; the loop ends once the
// divisor exceeds the quotient. A final division of the input by outside^2
// yields the inside part. Items are handled one at a time: start is taken
// only while busy is low.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// item in flight; no result is produced for it.
module square_part_splitter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [sps_pkg::VALUE_W-1:0]  i_value,
    output logic                         busy,
    output logic                         o_valid,
    output logic                         o_accepted,
    output logic [sps_pkg::OUT_W-1:0]    o_outside_part,
    output logic [sps_pkg::VALUE_W-1:0]  o_inside_part
);
    import sps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SQ   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [VALUE_W-1:0] r_rest, n_rest;
    logic [OUT_W-1:0]   r_outer, n_outer;
    logic [OUT_W-1:0]   r_d, n_d;
    logic               r_par, n_par;
    logic               r_strip, n_strip;
    logic               r_go, n_go;
    logic [VALUE_W-1:0] r_dvd, n_dvd;
    logic [VALUE_W-1:0] r_dvs, n_dvs;
    logic               r_valid, n_valid;
    logic               r_acc, n_acc;
    logic [OUT_W-1:0]   r_out, n_out;
    logic [VALUE_W-1:0] r_in, n_in;

    logic               div_done;
    t_div_res           div_res;
    logic [OUT_W-1:0]   mul_b;
    logic [VALUE_W-1:0] prod;
    logic [OUT_W-1:0]   d_next;

    sps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    assign mul_b  = (r_state == S_SQ) ? r_outer : r_d;
    assign prod   = VALUE_W'(r_outer) * VALUE_W'(mul_b);
    assign d_next = (r_d == OUT_W'(2)) ? OUT_W'(3) : r_d + OUT_W'(2);

    always_comb begin
        n_state = r_state;
        n_value = r_value;
        n_rest  = r_rest;
        n_outer = r_outer;
        n_d     = r_d;
        n_par   = r_par;
        n_strip = r_strip;
        n_go    = 1'b0;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        n_valid = 1'b0;
        n_acc   = r_acc;
        n_out   = r_out;
        n_in    = r_in;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_value > SPLIT_LIMIT) begin
                        n_valid = 1'b1;
                        n_acc   = 1'b0;
                        n_out   = '0;
                        n_in    = '0;
                    end else if (i_value == '0) begin
                        n_valid = 1'b1;
                        n_acc   = 1'b1;
                        n_out   = '0;
                        n_in    = VALUE_W'(1);
                    end else begin
                        n_value = i_value;
                        n_rest  = i_value;
                        n_outer = OUT_W'(1);
                        n_d     = OUT_W'(2);
                        n_par   = 1'b0;
                        n_strip = 1'b0;
                        n_dvd   = i_value;
                        n_dvs   = VALUE_W'(2);
                        n_go    = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (!r_strip && ({{(VALUE_W-OUT_W){1'b0}}, r_d} > div_res.quot)) begin
                        n_state = S_SQ;
                    end else if (div_res.rem == '0) begin
                        n_rest  = div_res.quot;
                        if (r_par) begin
                            n_outer = prod[OUT_W-1:0];
                        end
                        n_par   = ~r_par;
                        n_strip = 1'b1;
                        n_dvd   = div_res.quot;
                        n_dvs   = {{(VALUE_W-OUT_W){1'b0}}, r_d};
                        n_go    = 1'b1;
                    end else begin
                        n_d     = d_next;
                        n_par   = 1'b0;
                        n_strip = 1'b0;
                        n_dvd   = r_rest;
                        n_dvs   = {{(VALUE_W-OUT_W){1'b0}}, d_next};
                        n_go    = 1'b1;
                    end
                end
            end
            S_SQ: begin
                n_dvd   = r_value;
                n_dvs   = prod;
                n_go    = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (div_done) begin
                    n_valid = 1'b1;
                    n_acc   = 1'b1;
                    n_out   = r_outer;
                    n_in    = div_res.quot;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_rest  <= n_rest;
        r_outer <= n_outer;
        r_d     <= n_d;
        r_par   <= n_par;
        r_strip <= n_strip;
        r_dvd   <= n_dvd;
        r_dvs   <= n_dvs;
        r_acc   <= n_acc;
        r_out   <= n_out;
        r_in    <= n_in;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_accepted     = r_acc;
    assign o_outside_part = r_out;
    assign o_inside_part  = r_in;

`ifndef NO_ASSERTIONS
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_outside_part == '0 && o_inside_part == '0)
        else $error("rejected item carries nonzero parts");

    a_outer_zero_only_for_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted && o_outside_part == '0 |-> o_inside_part == VALUE_W'(1))
        else $error("zero outside part with inside part other than one");

    a_reject_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_value > SPLIT_LIMIT |=> o_valid && !o_accepted)
        else $error("oversized item not rejected in the next cycle");

    a_div_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV || r_state == S_FIN)
        else $error("division finished outside a waiting state");
`endif

endmodule

### rtl/sps_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sps_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [sps_pkg::VALUE_W-1:0]  i_dividend,
    input  logic [sps_pkg::VALUE_W-1:0]  i_divisor,
    output logic                         o_done,
    output sps_pkg::t_div_res            o_res
);
    import sps_pkg::*;

    logic               r_run;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] r_quo;
    logic [VALUE_W-1:0] r_dvs;

    logic [VALUE_W:0]   shifted;
    logic [VALUE_W:0]   diff;
    logic               fits;

    assign shifted = {r_rem, r_quo[VALUE_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_quo <= i_dividend;
                r_dvs <= i_divisor;
            end else if (r_run) begin
                r_rem <= fits ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
                r_quo <= {r_quo[VALUE_W-2:0], fits};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_res.quot = r_quo;
    assign o_res.rem  = r_rem;

endmodule

### bench/tb_square_part_splitter.sv
// Testbench for square_part_splitter: scoreboard with its own square split model.
`timescale 1ns / 1ps

import sps_pkg::*;

typedef struct packed {
    logic               accepted;
    logic [OUT_W-1:0]   outside_part;
    logic [VALUE_W-1:0] inside_part;
} split_t;

function automatic split_t split_square_parts(logic [VALUE_W-1:0] value);
    split_t          res;
    longint unsigned rest;
    longint unsigned outer;
    longint unsigned inner;
    longint unsigned d;
    int unsigned     mult;
    rest  = value;
    outer = 1;
    inner = 1;
    d     = 2;
    if (rest > SPLIT_LIMIT) begin
        res = '0;
        return res;
    end
    if (rest == 0) begin
        res.accepted     = 1'b1;
        res.outside_part = '0;
        res.inside_part  = 1;
        return res;
    end
    while (d <= rest / d) begin
        if (rest % d == 0) begin
            mult = 0;
            while (rest % d == 0) begin
                rest = rest / d;
                mult++;
            end
            for (int k = 0; k < mult / 2; k++)
                outer = outer * d;
            if (mult % 2 == 1)
                inner = inner * d;
        end
        d = (d == 2) ? 3 : d + 2;
    end
    if (rest > 1)
        inner = inner * rest;
    res.accepted     = 1'b1;
    res.outside_part = outer[OUT_W-1:0];
    res.inside_part  = inner[VALUE_W-1:0];
    return res;
endfunction

class square_split_board;
    split_t           expected_splits[$];
    int unsigned      mismatches;
    int unsigned      n_split;
    int unsigned      n_rejected;
    int unsigned      n_with_square;
    logic [OUT_W-1:0] max_outside;

    function new();
        mismatches    = 0;
        n_split       = 0;
        n_rejected    = 0;
        n_with_square = 0;
        max_outside   = '0;
    endfunction

    function void note_value(logic [VALUE_W-1:0] value);
        expected_splits.push_back(split_square_parts(value));
    endfunction

    function void report(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(split_t got);
        split_t want;
        if (expected_splits.size() == 0) begin
            report($sformatf("unexpected result acc=%0d out=%0d in=%0d",
                             got.accepted, got.outside_part, got.inside_part));
            return;
        end
        want = expected_splits.pop_front();
        if (got.accepted !== want.accepted)
            report($sformatf("accepted exp %0d got %0d", want.accepted, got.accepted));
        if (got.outside_part !== want.outside_part)
            report($sformatf("outside_part exp %0d got %0d",
                             want.outside_part, got.outside_part));
        if (got.inside_part !== want.inside_part)
            report($sformatf("inside_part exp %0d got %0d",
                             want.inside_part, got.inside_part));
        if (want.accepted) begin
            n_split++;
            if (want.outside_part > 1)
                n_with_square++;
            if (want.outside_part > max_outside)
                max_outside = want.outside_part;
        end else begin
            n_rejected++;
        end
    endfunction
endclass

module tb_square_part_splitter;

    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_W) - 1;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic [VALUE_W-1:0] i_value;
    logic               busy;
    logic               o_valid;
    logic               o_accepted;
    logic [OUT_W-1:0]   o_outside_part;
    logic [VALUE_W-1:0] o_inside_part;

    square_split_board board;
    int unsigned       no_idle_left;
    int unsigned       small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                            43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

    square_part_splitter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_value        (i_value),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_accepted     (o_accepted),
        .o_outside_part (o_outside_part),
        .o_inside_part  (o_inside_part)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result({o_accepted, o_outside_part, o_inside_part});
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle_left > 0) begin
            no_idle_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            no_idle_left = $urandom_range(5, 15);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // Keep every accepted value cheap to split: its second largest prime stays small.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned     r;
        longint unsigned v;
        longint unsigned p;
        longint unsigned c;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            v = {$urandom, $urandom};
            v = SPLIT_LIMIT + 1 + (v % (VALUE_MAX - SPLIT_LIMIT));
        end else if (r < 50) begin
            v = $urandom_range(0, 200000);
        end else if (r < 85) begin
            v = 1;
            repeat ($urandom_range(1, 10)) begin
                p = small_primes[$urandom_range(0, 24)];
                repeat ($urandom_range(1, 5)) begin
                    if (v * p <= SPLIT_LIMIT)
                        v = v * p;
                end
            end
            c = $urandom_range(1, 4096);
            if (v * c <= SPLIT_LIMIT)
                v = v * c;
        end else begin
            p = $urandom_range(2, 1000);
            v = p * p * $urandom_range(1, 1000);
        end
        return v[VALUE_W-1:0];
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] value);
        start   <= 1'b1;
        i_value <= value;
        do
            @(posedge i_clk);
        while (busy);
        board.note_value(value);
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int unsigned cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [VALUE_W-1:0] directed[$];
        board        = new();
        no_idle_left = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_value      = '0;
        directed = '{40'd0, 40'd1, 40'd2, 40'd3, 40'd4, 40'd8, 40'd12, 40'd36, 40'd72,
                     40'd9409, 40'd999983, 40'd4293918720, 40'd200560490130,
                     40'd549755813888, 40'd847288609443, 40'd999998000001,
                     SPLIT_LIMIT, SPLIT_LIMIT + 40'd1, 40'hFF_FFFF_FFFF,
                     40'h80_0000_0000};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[k]) begin
            send_value(directed[k]);
            idle_for(pick_gap());
        end
        repeat (100) begin
            send_value(pick_value());
            idle_for(pick_gap());
        end
        start <= 1'b0;
        while (board.expected_splits.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.expected_splits.size() > 0)
            board.report("expected result never arrived");
        $display("covered %0d results: %0d split (%0d with a square factor), %0d rejected",
                 board.n_split + board.n_rejected, board.n_split, board.n_with_square,
                 board.n_rejected);
        $display("largest outside part seen: %0d; mismatches: %0d",
                 board.max_outside, board.mismatches);
        if (board.mismatches == 0)
            $display("** square_part_splitter: PASSED **");
        else
            $display("** square_part_splitter: FAILED **");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("timeout with %0d results outstanding", board.expected_splits.size());
        $display("** square_part_splitter: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/sps_pkg.sv
rtl/sps_div.sv
rtl/square_part_splitter.sv
bench/tb_square_part_splitter.sv
